>>> rtl/bbsa_pkg.sv
// shared types and constants for the bracket balance checker
`timescale 1ns / 1ps
`default_nettype none

package bbsa_pkg;

  localparam int unsigned POS_W = 11;
  localparam int unsigned VAL_W = 12;
  localparam int unsigned CNT_W = 11;

  // largest positive prefix value, identity of the running minimum
  localparam logic [VAL_W-1:0] MIN_INIT = 12'h7FF;

  localparam logic [VAL_W-1:0] DELTA_P1 = 12'h001;
  localparam logic [VAL_W-1:0] DELTA_M1 = 12'hFFF;
  localparam logic [VAL_W-1:0] DELTA_P2 = 12'h002;
  localparam logic [VAL_W-1:0] DELTA_M2 = 12'hFFE;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_FLIP  = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  // what a wave does in each cell as it sweeps the cell memory
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_SCAN  = 2'd2
  } op_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [POS_W-1:0] position;
    logic             bracket_open;
  } item_t;

  typedef struct packed {
    logic                    balanced;
    logic signed [VAL_W-1:0] lowest_prefix;
    logic signed [VAL_W-1:0] net_balance;
  } res_t;

  typedef struct packed {
    logic             valid;
    op_e              op;
    logic [VAL_W-1:0] delta;
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] last_pos;
  } tok_t;

endpackage

`default_nettype wire

>>> rtl/bbsa_cell.sv
// one cell of the prefix chain: a slice of prefix balances and its local minimum
`timescale 1ns / 1ps
`default_nettype none

module bbsa_cell #(
  parameter int unsigned DEPTH   = 32,
  parameter int unsigned BASE    = 0,
  parameter int unsigned MAX_LEN = 1024
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  bbsa_pkg::tok_t                     tok_i,
  output bbsa_pkg::tok_t                     tok_o,
  input  wire                                min_valid_i,
  input  wire        [bbsa_pkg::VAL_W-1:0]   min_i,
  output logic                               min_valid_o,
  output logic       [bbsa_pkg::VAL_W-1:0]   min_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = $clog2(BASE + DEPTH + 1);
  localparam int unsigned CW = (PW > bbsa_pkg::POS_W) ? PW : bbsa_pkg::POS_W;

  logic [bbsa_pkg::VAL_W-1:0] mem_q [DEPTH];
  logic [bbsa_pkg::VAL_W-1:0] rd_q;

  bbsa_pkg::tok_t             cur_q;
  bbsa_pkg::tok_t             fwd_q;
  logic                       fwd_v_q;
  logic                       busy_q;
  logic                       wr_pend_q;
  logic [AW-1:0]              cnt_q;
  logic [AW-1:0]              wr_addr_q;
  logic [bbsa_pkg::VAL_W-1:0] lmin_q, lmin_d;
  logic [bbsa_pkg::VAL_W-1:0] min_q;
  logic                       min_v_q;

  logic [CW-1:0]              pos_w;
  logic                       in_rng;
  logic                       pos_live;
  logic [bbsa_pkg::VAL_W-1:0] new_val;
  logic                       wr_en;

  // one-based position of the entry being written back
  assign pos_w    = CW'(BASE + 1) + CW'(wr_addr_q);
  assign in_rng   = (pos_w >= CW'(cur_q.first_pos)) && (pos_w <= CW'(cur_q.last_pos));
  assign pos_live = (pos_w <= CW'(MAX_LEN));

  always_comb begin
    case (cur_q.op)
      bbsa_pkg::OP_CLEAR: begin
        new_val = '0;
        wr_en   = wr_pend_q;
      end
      bbsa_pkg::OP_ADD: begin
        new_val = in_rng ? (rd_q + cur_q.delta) : rd_q;
        wr_en   = wr_pend_q && in_rng;
      end
      default: begin
        new_val = rd_q;
        wr_en   = 1'b0;
      end
    endcase
  end

  always_comb begin
    lmin_d = lmin_q;
    if (tok_i.valid) begin
      lmin_d = bbsa_pkg::MIN_INIT;
    end else if (wr_pend_q && pos_live && ($signed(new_val) < $signed(lmin_q))) begin
      lmin_d = new_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      wr_pend_q <= 1'b0;
      cnt_q     <= '0;
      fwd_v_q   <= 1'b0;
      min_v_q   <= 1'b0;
    end else begin
      fwd_v_q   <= tok_i.valid;
      min_v_q   <= min_valid_i;
      wr_pend_q <= busy_q;
      if (tok_i.valid) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == AW'(DEPTH - 1)) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_i.valid) begin
      cur_q <= tok_i;
      fwd_q <= tok_i;
    end
    wr_addr_q <= cnt_q;
    lmin_q    <= lmin_d;
    if (min_valid_i) begin
      min_q <= ($signed(min_i) < $signed(lmin_q)) ? min_i : lmin_q;
    end
  end

  // slice memory: read during the sweep, each entry written back in the cycle after its read
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rd_q <= mem_q[cnt_q];
    end
    if (wr_en) begin
      mem_q[wr_addr_q] <= new_val;
    end
  end

  always_comb begin
    tok_o       = fwd_q;
    tok_o.valid = fwd_v_q;
  end

  assign min_valid_o = min_v_q;
  assign min_o       = min_q;

endmodule

`default_nettype wire

>>> rtl/bbsa_ctrl.sv
// command sequencer: bracket store, counts, wave launch and result register
`timescale 1ns / 1ps
`default_nettype none

module bbsa_ctrl #(
  parameter int unsigned MAX_LEN    = 1024,
  parameter int unsigned CELL_DEPTH = 32
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire      [bbsa_pkg::POS_W-1:0]   cfg_wdata_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  bbsa_pkg::item_t                  in_item_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output bbsa_pkg::res_t                   out_item_o,
  output bbsa_pkg::tok_t                   tok_o,
  output logic                             seed_valid_o,
  input  wire                              done_i,
  input  wire      [bbsa_pkg::VAL_W-1:0]   low_i
);

  localparam int unsigned IW      = $clog2(MAX_LEN);
  localparam int unsigned LW      = $clog2(MAX_LEN + 1);
  localparam int unsigned CW      = (LW > bbsa_pkg::POS_W) ? LW : bbsa_pkg::POS_W;
  localparam int unsigned WAIT_W  = $clog2(CELL_DEPTH + 3);
  localparam logic [WAIT_W-1:0] SEED_AT  = WAIT_W'(CELL_DEPTH + 1);
  localparam logic [WAIT_W-1:0] WAIT_MAX = WAIT_W'(CELL_DEPTH + 2);

  typedef enum logic [4:0] {
    ST_INIT = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_LOOK = 5'b00100,
    ST_RUN  = 5'b01000,
    ST_HOLD = 5'b10000
  } state_e;

  state_e                      state_q, state_d;
  logic [bbsa_pkg::POS_W-1:0]  seq_len_q;
  logic [bbsa_pkg::CNT_W-1:0]  open_q, open_d;
  logic [bbsa_pkg::CNT_W-1:0]  close_q, close_d;
  logic                        query_q, query_d;
  logic [bbsa_pkg::POS_W-1:0]  pos_q;
  logic [WAIT_W-1:0]           wait_q;
  logic                        seed_q;

  logic                        st_mem_q [MAX_LEN];
  logic                        st_rd_q;
  logic                        st_we, st_re, st_wdata;
  logic [IW-1:0]               st_waddr;
  logic [IW-1:0]               idx_in, idx_q;

  logic                        tok_v_q;
  bbsa_pkg::op_e               tok_op_q, l_op;
  logic [bbsa_pkg::VAL_W-1:0]  tok_delta_q, l_delta;
  logic [bbsa_pkg::POS_W-1:0]  tok_first_q, l_first;
  logic [bbsa_pkg::POS_W-1:0]  tok_last_q, last_pos;
  logic                        launch;

  logic                        acc;
  logic                        pos_ok;
  logic [CW-1:0]               max_c;
  logic                        out_free, out_load;
  logic                        out_v_q;
  bbsa_pkg::res_t              out_q, res;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;

  assign max_c    = CW'(MAX_LEN);
  assign pos_ok   = (in_item_i.position != '0) && (in_item_i.position <= seq_len_q)
                    && (CW'(in_item_i.position) <= max_c);
  // suffix ends at the smaller of the length and the array size
  assign last_pos = (CW'(seq_len_q) <= max_c) ? seq_len_q : max_c[bbsa_pkg::POS_W-1:0];

  assign idx_in = IW'({{IW{1'b0}}, in_item_i.position - 1'b1});
  assign idx_q  = IW'({{IW{1'b0}}, pos_q - 1'b1});

  always_comb begin
    state_d  = state_q;
    open_d   = open_q;
    close_d  = close_q;
    query_d  = query_q;
    launch   = 1'b0;
    l_op     = bbsa_pkg::OP_SCAN;
    l_delta  = '0;
    l_first  = pos_q;
    st_we    = 1'b0;
    st_re    = 1'b0;
    st_wdata = 1'b0;
    st_waddr = idx_q;
    case (state_q)
      ST_INIT: begin
        launch  = 1'b1;
        l_op    = bbsa_pkg::OP_CLEAR;
        query_d = 1'b0;
        state_d = ST_RUN;
      end
      ST_IDLE: begin
        if (acc) begin
          case (in_item_i.cmd)
            bbsa_pkg::CMD_LOAD: begin
              if (pos_ok) begin
                st_we    = 1'b1;
                st_waddr = idx_in;
                st_wdata = in_item_i.bracket_open;
                launch   = 1'b1;
                l_op     = bbsa_pkg::OP_ADD;
                l_first  = in_item_i.position;
                query_d  = 1'b0;
                state_d  = ST_RUN;
                if (in_item_i.bracket_open) begin
                  l_delta = bbsa_pkg::DELTA_P1;
                  open_d  = open_q + 1'b1;
                end else begin
                  l_delta = bbsa_pkg::DELTA_M1;
                  close_d = close_q + 1'b1;
                end
              end
            end
            bbsa_pkg::CMD_FLIP: begin
              if (pos_ok) begin
                st_re   = 1'b1;
                state_d = ST_LOOK;
              end
            end
            bbsa_pkg::CMD_QUERY: begin
              launch  = 1'b1;
              l_op    = bbsa_pkg::OP_SCAN;
              query_d = 1'b1;
              state_d = ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOOK: begin
        st_we    = 1'b1;
        st_wdata = ~st_rd_q;
        launch   = 1'b1;
        l_op     = bbsa_pkg::OP_ADD;
        query_d  = 1'b0;
        state_d  = ST_RUN;
        if (st_rd_q) begin
          l_delta = bbsa_pkg::DELTA_M2;
          open_d  = open_q - 1'b1;
          close_d = close_q + 1'b1;
        end else begin
          l_delta = bbsa_pkg::DELTA_P2;
          open_d  = open_q + 1'b1;
          close_d = close_q - 1'b1;
        end
      end
      ST_RUN: begin
        if (done_i) begin
          state_d = (query_q && !out_free) ? ST_HOLD : ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result fields
  always_comb begin
    res.lowest_prefix = low_i;
    res.net_balance   = {1'b0, open_q} - {1'b0, close_q};
    res.balanced      = !low_i[bbsa_pkg::VAL_W-1] && (open_q == close_q);
  end

  assign out_free = !out_v_q || out_ready_i;
  assign out_load = ((state_q == ST_RUN) && done_i && query_q && out_free)
                    || ((state_q == ST_HOLD) && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      seq_len_q <= '0;
      open_q    <= '0;
      close_q   <= '0;
      query_q   <= 1'b0;
      tok_v_q   <= 1'b0;
      wait_q    <= WAIT_MAX;
      seed_q    <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      open_q  <= open_d;
      close_q <= close_d;
      query_q <= query_d;
      tok_v_q <= launch;
      if (cfg_we_i) begin
        seq_len_q <= cfg_wdata_i;
      end
      if (launch) begin
        wait_q <= '0;
      end else if (wait_q != WAIT_MAX) begin
        wait_q <= wait_q + 1'b1;
      end
      seed_q <= (state_q == ST_RUN) && (wait_q == SEED_AT);
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      pos_q <= in_item_i.position;
    end
    if (launch) begin
      tok_op_q    <= l_op;
      tok_delta_q <= l_delta;
      tok_first_q <= l_first;
      tok_last_q  <= last_pos;
    end
    if (out_load) begin
      out_q <= res;
    end
  end

  // bracket store, one bit per position
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem_q[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rd_q <= st_mem_q[idx_in];
    end
  end

  always_comb begin
    tok_o.valid     = tok_v_q;
    tok_o.op        = tok_op_q;
    tok_o.delta     = tok_delta_q;
    tok_o.first_pos = tok_first_q;
    tok_o.last_pos  = tok_last_q;
  end

  assign seed_valid_o = seed_q;
  assign out_valid_o  = out_v_q;
  assign out_item_o   = out_q;

endmodule

`default_nettype wire

>>> rtl/bracket_balance_suffix_add_min_tree.sv
// top level: sequencer plus a chain of prefix cells holding the balances
// one item at a time: in_ready_o is low until its wave is done and a query's result is loaded (a flip adds a lookup)
// each item waits for the wave's walk down the cell chain plus one sweep of a cell memory
// a query result is loaded once the minimum leaves the last cell and out_q is free
// after reset a clearing wave zeroes all balances while in_ready_o stays low;
// configuration writes are taken throughout
`timescale 1ns / 1ps
`default_nettype none

module bracket_balance_suffix_add_min_tree #(
  parameter int unsigned MAX_LEN    = 1024,
  parameter int unsigned CELL_DEPTH = 32
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire     [bbsa_pkg::POS_W-1:0]   cfg_wdata_i,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  bbsa_pkg::item_t                 in_item_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output bbsa_pkg::res_t                  out_item_o
);

  // each cell owns CELL_DEPTH consecutive positions; the last may be partly unused
  localparam int unsigned NUM_CELLS = (MAX_LEN + CELL_DEPTH - 1) / CELL_DEPTH;

  // wave tokens hop one cell per cycle; running minimum follows the same way
  bbsa_pkg::tok_t             tok_w  [NUM_CELLS];
  logic                       minv_w [NUM_CELLS+1];
  logic [bbsa_pkg::VAL_W-1:0] min_w  [NUM_CELLS+1];

  bbsa_ctrl #(
    .MAX_LEN    (MAX_LEN),
    .CELL_DEPTH (CELL_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o),
    .tok_o        (tok_w[0]),
    .seed_valid_o (minv_w[0]),
    .done_i       (minv_w[NUM_CELLS]),
    .low_i        (min_w[NUM_CELLS])
  );

  // seed of the minimum chain: the largest value, timed to meet cell 0's sweep end
  assign min_w[0] = bbsa_pkg::MIN_INIT;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    if (k == NUM_CELLS - 1) begin : g_last
      // last cell: its token has nowhere to go, its minimum is the answer
      bbsa_cell #(
        .DEPTH   (CELL_DEPTH),
        .BASE    (k * CELL_DEPTH),
        .MAX_LEN (MAX_LEN)
      ) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .tok_i       (tok_w[k]),
        .tok_o       (),
        .min_valid_i (minv_w[k]),
        .min_i       (min_w[k]),
        .min_valid_o (minv_w[k+1]),
        .min_o       (min_w[k+1])
      );
    end else begin : g_mid
      bbsa_cell #(
        .DEPTH   (CELL_DEPTH),
        .BASE    (k * CELL_DEPTH),
        .MAX_LEN (MAX_LEN)
      ) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .tok_i       (tok_w[k]),
        .tok_o       (tok_w[k+1]),
        .min_valid_i (minv_w[k]),
        .min_i       (min_w[k]),
        .min_valid_o (minv_w[k+1]),
        .min_o       (min_w[k+1])
      );
    end
  end

endmodule

`default_nettype wire

>>> rtl/bbsa_checker.sv
// port-level checks for the bracket balance checker, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module bbsa_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             in_valid_i,
  input wire                             in_ready_o,
  input bbsa_pkg::item_t                 in_item_i,
  input wire                             out_valid_o,
  input wire                             out_ready_i,
  input bbsa_pkg::res_t                  out_item_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed or dropped while stalled");

  // a query occupies the block, so no item is taken in the next cycle
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.cmd == bbsa_pkg::CMD_QUERY) |=> !in_ready_o)
    else $error("item accepted right after a query");

  // balanced means no negative prefix and zero net count
  a_balanced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_item_o.balanced
                     || (!out_item_o.lowest_prefix[bbsa_pkg::VAL_W-1]
                         && (out_item_o.net_balance == '0))))
    else $error("balanced flag disagrees with prefix or net count");

  // clearing pass runs right after reset
  a_clear_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("ready during clearing pass");

endmodule

bind bracket_balance_suffix_add_min_tree bbsa_checker u_bbsa_checker (.*);

`default_nettype wire
